[rtl/sps_pkg.sv]
// ----------------------------------------------------------------------------
// sps_pkg
// Shared types and constants of the sampled predecessor search block.
// ----------------------------------------------------------------------------
package sps_pkg;

	// Default sizes of the key table
	localparam int MAX_ENTRIES_DEF   = 1024;
	localparam int SAMPLE_STRIDE_DEF = 32;
	localparam int KEY_WIDTH_DEF     = 40;

	// Fixed field widths of the ports
	localparam int INDEX_W = 10;
	localparam int KEY_W   = 40;
	localparam int COUNT_W = 11;
	localparam int APB_AW  = 3;
	localparam int APB_DW  = 32;

	// Window span (r - l) at or below which the search turns to a linear scan
	localparam int SCAN_SPAN = 7;

	// Item kinds
	localparam logic ACTION_LOAD  = 1'b0;
	localparam logic ACTION_QUERY = 1'b1;

	// Register index (word address bit)
	localparam logic REG_ENTRY_COUNT = 1'b0;

	typedef struct packed {
		logic               action;
		logic [INDEX_W-1:0] entry_index;
		logic [KEY_W-1:0]   entry_key;
		logic [KEY_W-1:0]   query_position;
	} in_item_t;

	typedef struct packed {
		logic [INDEX_W-1:0] pred_index;
		logic               found;
	} out_item_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load_capture;
		logic load_write;
		logic query_start;
		logic samp_step;
		logic samp_done;
		logic bin_issue;
		logic bin_update;
		logic scan_start;
		logic scan_step;
		logic emit_hit;
		logic emit_empty;
	} cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic count_zero;
		logic samp_more;
		logic bin_wide;
		logic bin_move;
		logic scan_move;
	} stat_t;

endpackage

[rtl/sps_ctrl.sv]
// ----------------------------------------------------------------------------
// sps_ctrl
// Sequencer of the search: load, sample scan, halving, linear scan, result.
// ----------------------------------------------------------------------------
module sps_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic           action,
	input  sps_pkg::stat_t stat,
	output sps_pkg::cmd_t  cmd,
	output logic           busy
);
	import sps_pkg::*;

	localparam logic [2:0] S_IDLE       = 3'd0;
	localparam logic [2:0] S_LOAD       = 3'd1;
	localparam logic [2:0] S_EMPTY      = 3'd2;
	localparam logic [2:0] S_SAMP       = 3'd3;
	localparam logic [2:0] S_BIN_ISSUE  = 3'd4;
	localparam logic [2:0] S_BIN_CMP    = 3'd5;
	localparam logic [2:0] S_SCAN_ISSUE = 3'd6;
	localparam logic [2:0] S_SCAN       = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign busy = (state_q != S_IDLE);

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					if (action == ACTION_LOAD) begin
						cmd.load_capture = 1'b1;
						state_d          = S_LOAD;
					end else begin
						cmd.query_start = 1'b1;
						state_d         = stat.count_zero ? S_EMPTY : S_SAMP;
					end
				end
			end
			S_LOAD: begin
				cmd.load_write = 1'b1;
				state_d        = S_IDLE;
			end
			S_EMPTY: begin
				cmd.emit_empty = 1'b1;
				state_d        = S_IDLE;
			end
			S_SAMP: begin
				if (stat.samp_more) begin
					cmd.samp_step = 1'b1;
				end else begin
					cmd.samp_done = 1'b1;
					state_d       = S_BIN_ISSUE;
				end
			end
			S_BIN_ISSUE: begin
				if (stat.bin_wide) begin
					cmd.bin_issue = 1'b1;
					state_d       = S_BIN_CMP;
				end else begin
					cmd.scan_start = 1'b1;
					state_d        = S_SCAN;
				end
			end
			S_BIN_CMP: begin
				if (stat.bin_move) begin
					cmd.bin_update = 1'b1;
					state_d        = S_BIN_ISSUE;
				end else begin
					state_d = S_SCAN_ISSUE;
				end
			end
			S_SCAN_ISSUE: begin
				cmd.scan_start = 1'b1;
				state_d        = S_SCAN;
			end
			S_SCAN: begin
				if (stat.scan_move) begin
					cmd.scan_step = 1'b1;
				end else begin
					cmd.emit_hit = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Hold the state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[rtl/sps_datapath.sv]
// ----------------------------------------------------------------------------
// sps_datapath
// Key and sample memories, search window registers and result register.
// ----------------------------------------------------------------------------
module sps_datapath #(
	parameter int MAX_ENTRIES   = sps_pkg::MAX_ENTRIES_DEF,
	parameter int SAMPLE_STRIDE = sps_pkg::SAMPLE_STRIDE_DEF,
	parameter int KEY_WIDTH     = sps_pkg::KEY_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  sps_pkg::cmd_t               cmd,
	output sps_pkg::stat_t              stat,
	input  sps_pkg::in_item_t           request,
	input  logic [sps_pkg::COUNT_W-1:0] entry_count,
	output sps_pkg::out_item_t          result,
	output logic                        done
);
	import sps_pkg::*;

	localparam int SDEPTH = (MAX_ENTRIES + SAMPLE_STRIDE - 1) / SAMPLE_STRIDE;
	localparam int IW     = $clog2(MAX_ENTRIES);
	localparam int NW     = $clog2(MAX_ENTRIES + 1);
	localparam int BW     = $clog2(MAX_ENTRIES + SAMPLE_STRIDE);
	localparam int CMW    = (NW > COUNT_W) ? NW : COUNT_W;
	localparam int SAW    = (SDEPTH > 1) ? $clog2(SDEPTH) : 1;
	localparam int SW     = $clog2(SDEPTH + 1);
	// Division of a load index by the stride through a reciprocal
	localparam int SL     = $clog2(SAMPLE_STRIDE);
	localparam int SH     = INDEX_W + SL;
	localparam int RW     = SH - SL + 1;
	localparam int RECIP  = ((1 << SH) + SAMPLE_STRIDE - 1) / SAMPLE_STRIDE;
	localparam int PW     = INDEX_W + RW;
	localparam int QW     = PW - SH;
	localparam int MW     = QW + $clog2(SAMPLE_STRIDE + 1);

	logic [KEY_WIDTH-1:0] key_mem  [MAX_ENTRIES];
	logic [KEY_WIDTH-1:0] samp_mem [SDEPTH];

	logic [KEY_WIDTH-1:0] key_a_q;
	logic [KEY_WIDTH-1:0] key_b_q;
	logic [KEY_WIDTH-1:0] samp_q;
	logic [KEY_WIDTH-1:0] x_q;
	logic [IW-1:0]        l_q;
	logic [IW-1:0]        r_q;
	logic [IW-1:0]        m_q;
	logic [NW-1:0]        n_q;
	logic [BW-1:0]        base_q;
	logic [SW-1:0]        i_q;
	logic [INDEX_W-1:0]   ld_idx_s1;
	logic [KEY_WIDTH-1:0] ld_key_s1;
	logic [QW-1:0]        ld_quot_s1;
	out_item_t            result_q;
	logic                 done_q;

	logic [CMW-1:0] cnt_ext;
	logic [CMW-1:0] n_clip;
	logic [PW-1:0]  quot_prod;
	logic [MW-1:0]  back_prod;
	logic           ld_range;
	logic           ld_sample;
	logic [IW:0]    mid_sum;
	logic [IW-1:0]  mid;
	logic [IW-1:0]  win_diff;
	logic [BW-1:0]  n_b;
	logic [BW-1:0]  lim;
	logic [BW-1:0]  l_new;
	logic [IW-1:0]  addr_a;
	logic [IW-1:0]  addr_b;
	logic [SAW-1:0] samp_addr;
	logic           key_above;
	logic           next_below;

	// Clip the key count to the table size
	assign cnt_ext = CMW'(entry_count);
	assign n_clip  = (cnt_ext > CMW'(MAX_ENTRIES)) ? CMW'(MAX_ENTRIES) : cnt_ext;

	// Split a load index into sample slot and remainder
	assign quot_prod = PW'(request.entry_index) * PW'(RECIP);
	assign back_prod = MW'(ld_quot_s1) * MW'(SAMPLE_STRIDE);
	assign ld_sample = (back_prod == MW'(ld_idx_s1));
	assign ld_range  = (CMW'(ld_idx_s1) < CMW'(MAX_ENTRIES));

	// Window arithmetic
	assign mid_sum  = {1'b0, l_q} + {1'b0, r_q};
	assign mid      = mid_sum[IW:1];
	assign win_diff = r_q - l_q;
	assign n_b      = BW'(n_q);

	// Window picked by the sample scan
	always_comb begin
		if (base_q == '0) begin
			lim   = (n_b < BW'(SAMPLE_STRIDE)) ? n_b : BW'(SAMPLE_STRIDE);
			l_new = '0;
		end else begin
			lim   = (base_q < n_b) ? base_q : n_b;
			l_new = base_q - BW'(SAMPLE_STRIDE);
		end
	end

	// Compare keys read at the probe and the entry after it
	assign key_above  = (key_a_q > x_q);
	assign next_below = (key_b_q <= x_q);

	assign stat.count_zero = (entry_count == '0);
	assign stat.samp_more  = (base_q < n_b) && (samp_q <= x_q);
	assign stat.bin_wide   = (32'(win_diff) > 32'(SCAN_SPAN));
	assign stat.bin_move   = key_above || next_below;
	assign stat.scan_move  = (m_q < r_q) && (key_above || next_below);

	// Read addresses; the scan reads one entry ahead
	always_comb begin
		if (cmd.bin_issue) begin
			addr_a = mid;
			addr_b = mid + IW'(1);
		end else if (cmd.scan_start) begin
			addr_a = l_q;
			addr_b = l_q + IW'(1);
		end else begin
			addr_a = m_q + IW'(1);
			addr_b = m_q + IW'(2);
		end
	end

	assign samp_addr = cmd.query_start ? '0 : SAW'(i_q + SW'(1));

	// Key memory: one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (cmd.load_write && ld_range) begin
			key_mem[IW'(ld_idx_s1)] <= ld_key_s1;
		end
		key_a_q <= key_mem[addr_a];
		key_b_q <= key_mem[addr_b];
	end

	// Sample memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.load_write && ld_range && ld_sample) begin
			samp_mem[SAW'(ld_quot_s1)] <= ld_key_s1;
		end
		samp_q <= samp_mem[samp_addr];
	end

	// Capture a load and its sample slot
	always_ff @(posedge clk) begin
		if (cmd.load_capture) begin
			ld_idx_s1  <= request.entry_index;
			ld_key_s1  <= KEY_WIDTH'(request.entry_key);
			ld_quot_s1 <= quot_prod[PW-1:SH];
		end
	end

	// Search registers
	always_ff @(posedge clk) begin
		if (cmd.query_start) begin
			x_q    <= KEY_WIDTH'(request.query_position);
			n_q    <= NW'(n_clip);
			i_q    <= '0;
			base_q <= '0;
		end
		if (cmd.samp_step) begin
			i_q    <= i_q + SW'(1);
			base_q <= base_q + BW'(SAMPLE_STRIDE);
		end
		if (cmd.samp_done) begin
			l_q <= IW'(l_new);
			r_q <= IW'(lim - BW'(1));
		end
		if (cmd.bin_issue) begin
			m_q <= mid;
		end
		if (cmd.bin_update) begin
			if (key_above) begin
				r_q <= m_q - IW'(1);
			end else begin
				l_q <= m_q + IW'(1);
			end
		end
		if (cmd.scan_start) begin
			m_q <= l_q;
		end
		if (cmd.scan_step) begin
			m_q <= m_q + IW'(1);
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (cmd.emit_hit) begin
			result_q.found      <= !key_above;
			result_q.pred_index <= key_above ? '0 : INDEX_W'(m_q);
		end else if (cmd.emit_empty) begin
			result_q.found      <= 1'b0;
			result_q.pred_index <= '0;
		end
	end

	// Result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.emit_hit || cmd.emit_empty;
		end
	end

	assign result = result_q;
	assign done   = done_q;

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && !result_q.found |-> result_q.pred_index == '0)
		else $error("miss result carries a nonzero index");

	a_scan_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_step |-> m_q < r_q)
		else $error("scan stepped past the window end");

	a_bin_window: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.bin_issue |-> r_q > l_q)
		else $error("halving issued on an empty window");

endmodule

[rtl/sampled_predecessor_search.sv]
// ----------------------------------------------------------------------------
// sampled_predecessor_search
// Predecessor search over a table of sorted keys with a sampled first level.
//
//   channel   direction  handshake            payload
//   request   in         start && !busy       in_item_t (load or query)
//   result    out        done (one cycle)     out_item_t (query only)
//   config    in         APB write            entry_count at byte 0
//
// A load holds busy while in S_LOAD, where it writes the key, and gives no
// result. A query strobes its result after a sample scan (one sample
// memory read per sample passed), halving steps and scan steps (one key
// memory read pair each); when a halving compare lands on the answer, the
// scan is entered through S_SCAN_ISSUE. An empty table answers through
// S_EMPTY without a search. Reset clears control state and the entry count
// register only; the memories stay as they are until loaded. Results cannot
// be stalled.
// ----------------------------------------------------------------------------
module sampled_predecessor_search #(
	parameter int MAX_ENTRIES   = sps_pkg::MAX_ENTRIES_DEF,
	parameter int SAMPLE_STRIDE = sps_pkg::SAMPLE_STRIDE_DEF,
	parameter int KEY_WIDTH     = sps_pkg::KEY_WIDTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  sps_pkg::in_item_t          request,
	output logic                       done,
	output sps_pkg::out_item_t         result,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [sps_pkg::APB_AW-1:0] paddr,
	input  logic [sps_pkg::APB_DW-1:0] pwdata,
	output logic [sps_pkg::APB_DW-1:0] prdata,
	output logic                       pready
);
	import sps_pkg::*;

	cmd_t               cmd;
	stat_t              stat;
	logic [COUNT_W-1:0] entry_count_q;
	logic               reg_wr;

	// Register file: one count register
	assign pready = 1'b1;
	assign reg_wr = psel && penable && pwrite && (paddr[2] == REG_ENTRY_COUNT);
	assign prdata = (paddr[2] == REG_ENTRY_COUNT) ? APB_DW'(entry_count_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
		end else if (reg_wr) begin
			entry_count_q <= pwdata[COUNT_W-1:0];
		end
	end

	sps_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.action (request.action),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	sps_datapath #(
		.MAX_ENTRIES   (MAX_ENTRIES),
		.SAMPLE_STRIDE (SAMPLE_STRIDE),
		.KEY_WIDTH     (KEY_WIDTH)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.request     (request),
		.entry_count (entry_count_q),
		.result      (result),
		.done        (done)
	);

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while a search is still running");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("transfer accepted without going busy");

endmodule
